// File: hdl/dcle_pkg.sv
package dcle_pkg;

	localparam int OFFSET_WIDTH_DEF = 32;
	// wide enough for any offset width up to 32 plus sign and carry
	localparam int CALC_W = 34;
	localparam int MAX_RESULTS = 8;
	localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [CALC_W-1:0] PIECE_MAX = CALC_W'(34'h0_7FFF_FFFF);
	localparam logic [CALC_W-1:0] SPLIT_AT = CALC_W'(34'h0_8000_0000);
	localparam logic [31:0] NEG_PIECE = 32'h8000_0001;

	localparam logic OPC_COPY = 1'b0;
	localparam logic OPC_FINISH = 1'b1;
	localparam logic KIND_EXT = 1'b0;
	localparam logic KIND_INT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXT,
		ST_INT,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_EXT,
		OP_INT,
		OP_FIN
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
		logic emit;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic ext_final;
		logic int_final;
		logic nlen_zero;
		logic cnt_zero;
		logic ld_olen_zero;
		logic ld_nlen_zero;
	} sts_t;

endpackage

// File: hdl/dcle_ctrl.sv
module dcle_ctrl import dcle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic opcode,
	output logic item_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;
	logic [RES_CNT_W-1:0] res_cnt_q;
	logic emit_ok;
	logic go;

	always_comb begin
		case (state_q)
			ST_FIN: emit_ok = !sts.cnt_zero && (res_cnt_q < RES_CNT_W'(MAX_RESULTS));
			default: emit_ok = res_cnt_q < RES_CNT_W'(MAX_RESULTS);
		endcase
		// a silent step (record past the limit, or a finish with no external count pending) need not wait for the output slot
		go = (state_q != ST_IDLE) && (!emit_ok || sts.slot_free);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (opcode == OPC_FINISH)
						state_nxt = ST_FIN;
					else if (!sts.ld_olen_zero)
						state_nxt = ST_EXT;
					else if (!sts.ld_nlen_zero)
						state_nxt = ST_INT;
				end
			end
			ST_EXT: begin
				if (go && sts.ext_final)
					state_nxt = sts.nlen_zero ? ST_IDLE : ST_INT;
			end
			ST_INT: begin
				if (go && sts.int_final)
					state_nxt = ST_IDLE;
			end
			ST_FIN: begin
				if (go)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load = 1'b0;
		cmd.op = OP_NONE;
		cmd.emit = 1'b0;
		cmd.last = 1'b0;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				cmd.load = item_valid;
			end
			ST_EXT: begin
				cmd.op = go ? OP_EXT : OP_NONE;
				cmd.emit = go && emit_ok;
				cmd.last = sts.ext_final && sts.nlen_zero;
			end
			ST_INT: begin
				cmd.op = go ? OP_INT : OP_NONE;
				cmd.emit = go && emit_ok;
				cmd.last = sts.int_final;
			end
			ST_FIN: begin
				cmd.op = go ? OP_FIN : OP_NONE;
				cmd.emit = go && emit_ok;
				cmd.last = 1'b1;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
		// the eighth record closes the item whatever follows
		if (res_cnt_q == RES_CNT_W'(MAX_RESULTS - 1))
			cmd.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load)
				res_cnt_q <= '0;
			else if (cmd.emit)
				res_cnt_q <= res_cnt_q + RES_CNT_W'(1);
		end
	end

endmodule

// File: hdl/dcle_datapath.sv
module dcle_datapath import dcle_pkg::*; #(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        old_offset,
	input  logic [31:0]        old_length,
	input  logic [31:0]        new_length,
	input  cmd_t               cmd,
	output sts_t               sts,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               kind,
	output logic signed [31:0] offset_delta,
	output logic [30:0]        copy_length,
	output logic [31:0]        ext_run_count,
	output logic [30:0]        data_length,
	output logic               last
);

	localparam int W = OFFSET_WIDTH;

	logic [W:0]   off_q;
	logic [W-1:0] olen_q;
	logic [W-1:0] nlen_q;
	logic [W:0]   run_q;
	logic [31:0]  cnt_q;
	logic         valid_q;

	logic [CALC_W-1:0] off_x, run_x, olen_x, nlen_x, diff_x, bdiff_x;
	logic [CALC_W-1:0] run_fwd_x, run_bwd_x, run_end_x, olen_rem_x, nlen_rem_x;
	logic fwd, bwd, long_copy, long_lit;

	logic        rec_kind;
	logic [31:0] rec_delta;
	logic [30:0] rec_clen;
	logic [31:0] rec_run;
	logic [30:0] rec_dlen;

	always_comb begin
		off_x = CALC_W'(off_q);
		run_x = CALC_W'(run_q);
		olen_x = CALC_W'(olen_q);
		nlen_x = CALC_W'(nlen_q);
		diff_x = off_x - run_x;
		bdiff_x = run_x - off_x;
		fwd = (off_x > run_x) && (diff_x >= SPLIT_AT);
		bwd = (run_x > off_x) && (bdiff_x >= SPLIT_AT);
		long_copy = olen_x >= SPLIT_AT;
		long_lit = nlen_x >= SPLIT_AT;
		run_fwd_x = run_x + PIECE_MAX;
		run_bwd_x = run_x - PIECE_MAX;
		run_end_x = off_x + olen_x;
		olen_rem_x = olen_x - PIECE_MAX;
		nlen_rem_x = nlen_x - PIECE_MAX;
	end

	always_comb begin
		rec_kind = KIND_EXT;
		rec_delta = '0;
		rec_clen = '0;
		rec_run = '0;
		rec_dlen = '0;
		case (cmd.op)
			OP_EXT: begin
				if (fwd)
					rec_delta = PIECE_MAX[31:0];
				else if (bwd)
					rec_delta = NEG_PIECE;
				else begin
					rec_delta = diff_x[31:0];
					rec_clen = long_copy ? PIECE_MAX[30:0] : olen_x[30:0];
				end
			end
			OP_INT: begin
				rec_kind = KIND_INT;
				rec_run = cnt_q;
				rec_dlen = long_lit ? PIECE_MAX[30:0] : nlen_x[30:0];
			end
			OP_FIN: begin
				rec_kind = KIND_INT;
				rec_run = cnt_q;
			end
			default: rec_kind = KIND_EXT;
		endcase
	end

	always_comb begin
		sts.slot_free = !valid_q || !result_stall;
		sts.ext_final = !fwd && !bwd && !long_copy;
		sts.int_final = !long_lit;
		sts.nlen_zero = nlen_q == '0;
		sts.cnt_zero = cnt_q == '0;
		sts.ld_olen_zero = old_length[W-1:0] == '0;
		sts.ld_nlen_zero = new_length[W-1:0] == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			cnt_q <= '0;
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_EXT: begin
					cnt_q <= cnt_q + 32'd1;
					if (fwd)
						run_q <= run_fwd_x[W:0];
					else if (bwd)
						run_q <= run_bwd_x[W:0];
					else if (long_copy)
						run_q <= run_fwd_x[W:0];
					else
						run_q <= run_end_x[W:0];
				end
				OP_INT: cnt_q <= '0;
				OP_FIN: begin
					cnt_q <= '0;
					run_q <= '0;
				end
				default: cnt_q <= cnt_q;
			endcase
			if (cmd.emit)
				valid_q <= 1'b1;
			else if (!result_stall)
				valid_q <= 1'b0;
		end
	end

	// item fields and the result register carry no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			off_q <= {1'b0, old_offset[W-1:0]};
			olen_q <= old_length[W-1:0];
			nlen_q <= new_length[W-1:0];
		end else if (cmd.op == OP_EXT && !fwd && !bwd && long_copy) begin
			// next piece starts where this one ends, with zero jump
			olen_q <= olen_rem_x[W-1:0];
			off_q <= run_fwd_x[W:0];
		end else if (cmd.op == OP_INT && long_lit) begin
			nlen_q <= nlen_rem_x[W-1:0];
		end
		if (cmd.emit) begin
			kind <= rec_kind;
			offset_delta <= rec_delta;
			copy_length <= rec_clen;
			ext_run_count <= rec_run;
			data_length <= rec_dlen;
			last <= cmd.last;
		end
	end

	assign result_valid = valid_q;

endmodule

// File: hdl/delta_copy_list_encoder.sv
// Timing: an item is taken while the control is idle; each record is then built by
// the datapath's record step and shows on the result register in the cycle after.
// Occupancy: the block takes no new item until it has stepped through every record
// of the last one, a finish included; output stalls hold it longer.
// Reset: arst_n clears the running offset, the pending external count and all
// control state at once; the block then takes items immediately.
module delta_copy_list_encoder import dcle_pkg::*; #(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               opcode,
	input  logic [31:0]        old_offset,
	input  logic [31:0]        old_length,
	input  logic [31:0]        new_length,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               kind,
	output logic signed [31:0] offset_delta,
	output logic [30:0]        copy_length,
	output logic [31:0]        ext_run_count,
	output logic [30:0]        data_length,
	output logic               last
);

	cmd_t cmd;
	sts_t sts;

	dcle_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.opcode     (opcode),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	dcle_datapath #(
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.old_offset    (old_offset),
		.old_length    (old_length),
		.new_length    (new_length),
		.cmd           (cmd),
		.sts           (sts),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.offset_delta  (offset_delta),
		.copy_length   (copy_length),
		.ext_run_count (ext_run_count),
		.data_length   (data_length),
		.last          (last)
	);

`ifndef NO_ASSERTIONS
	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.slot_free)
		else $error("record emitted into an occupied result register");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |-> (cmd.load && cmd.op == OP_NONE))
		else $error("item transfer without a clean load");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_FIN |=> sts.cnt_zero)
		else $error("external count not cleared by finish");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> result_valid)
		else $error("emitted record not presented");
`endif

endmodule

// File: dv/dcle_record_checker.sv
`timescale 1ns / 1ps

module dcle_record_checker import dcle_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic               opcode,
	input  logic [31:0]        old_offset,
	input  logic [31:0]        old_length,
	input  logic [31:0]        new_length,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic               kind,
	input  logic signed [31:0] offset_delta,
	input  logic [30:0]        copy_length,
	input  logic [31:0]        ext_run_count,
	input  logic [30:0]        data_length,
	input  logic               last,
	output int                 fail_count,
	output int                 outstanding,
	output int                 seen_records
);

	typedef struct packed {
		logic        kind;
		logic [31:0] offset_delta;
		logic [30:0] copy_length;
		logic [31:0] ext_run_count;
		logic [30:0] data_length;
		logic        last;
	} copy_rec_t;

	// running old position and external records not yet counted
	logic [32:0] run_pos = '0;
	logic [31:0] ext_pending = '0;

	copy_rec_t item_records[$];
	copy_rec_t expected_records[$];
	copy_rec_t want;

	initial begin
		fail_count = 0;
		outstanding = 0;
		seen_records = 0;
	end

	// records past the eighth of one item are dropped
	function automatic void stage_record(input logic k, input logic [31:0] delta,
			input logic [30:0] clen, input logic [31:0] runs, input logic [30:0] dlen);
		copy_rec_t r;
		if (item_records.size() < MAX_RESULTS) begin
			r.kind = k;
			r.offset_delta = delta;
			r.copy_length = clen;
			r.ext_run_count = runs;
			r.data_length = dlen;
			r.last = 1'b0;
			item_records.push_back(r);
		end
	endfunction

	function automatic void encode_item(input logic op, input logic [31:0] off_in,
			input logic [31:0] olen_in, input logic [31:0] nlen_in);
		logic [32:0] off;
		logic [32:0] jump;
		logic [31:0] olen;
		logic [31:0] nlen;
		logic [31:0] piece;
		bit          more;
		copy_rec_t   r;
		item_records.delete();
		off = {1'b0, off_in};
		olen = olen_in;
		nlen = nlen_in;
		if (op == OPC_FINISH) begin
			if (ext_pending != 0)
				stage_record(KIND_INT, '0, '0, ext_pending, '0);
			run_pos = '0;
			ext_pending = '0;
		end else begin
			if (olen != 0) begin
				more = 1'b1;
				while (more) begin
					if (off > run_pos && off - run_pos >= SPLIT_AT) begin
						stage_record(KIND_EXT, PIECE_MAX[31:0], '0, '0, '0);
						ext_pending++;
						run_pos = run_pos + PIECE_MAX[32:0];
					end else if (off < run_pos && run_pos - off >= SPLIT_AT) begin
						stage_record(KIND_EXT, NEG_PIECE, '0, '0, '0);
						ext_pending++;
						run_pos = run_pos - PIECE_MAX[32:0];
					end else begin
						jump = off - run_pos;
						if (olen >= SPLIT_AT[31:0]) begin
							// later pieces of a long copy start where the last one ended
							stage_record(KIND_EXT, jump[31:0], PIECE_MAX[30:0], '0, '0);
							ext_pending++;
							olen = olen - PIECE_MAX[31:0];
							run_pos = run_pos + PIECE_MAX[32:0];
							off = run_pos;
						end else begin
							stage_record(KIND_EXT, jump[31:0], olen[30:0], '0, '0);
							ext_pending++;
							run_pos = off + {1'b0, olen};
							more = 1'b0;
						end
					end
				end
			end
			if (nlen != 0) begin
				more = 1'b1;
				while (more) begin
					piece = (nlen >= SPLIT_AT[31:0]) ? PIECE_MAX[31:0] : nlen;
					stage_record(KIND_INT, '0, '0, ext_pending, piece[30:0]);
					ext_pending = '0;
					if (nlen >= SPLIT_AT[31:0])
						nlen = nlen - PIECE_MAX[31:0];
					else
						more = 1'b0;
				end
			end
		end
		if (item_records.size() > 0) begin
			r = item_records.pop_back();
			r.last = 1'b1;
			item_records.push_back(r);
		end
		foreach (item_records[i])
			expected_records.push_back(item_records[i]);
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected 0x%08h, actual 0x%08h", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_records.delete();
			run_pos = '0;
			ext_pending = '0;
		end else begin
			// compare before predicting: a record never belongs to the item taken this edge
			if (result_valid && !result_stall) begin
				seen_records++;
				if (expected_records.size() == 0) begin
					$error("record transfer with nothing expected: kind %0d delta 0x%08h",
						kind, offset_delta);
					fail_count++;
				end else begin
					want = expected_records.pop_front();
					check_field("kind", 32'(want.kind), 32'(kind));
					check_field("offset_delta", want.offset_delta, offset_delta);
					check_field("copy_length", 32'(want.copy_length), 32'(copy_length));
					check_field("ext_run_count", want.ext_run_count, ext_run_count);
					check_field("data_length", 32'(want.data_length), 32'(data_length));
					check_field("last", 32'(want.last), 32'(last));
				end
			end
			if (item_valid && !item_stall)
				encode_item(opcode, old_offset, old_length, new_length);
		end
		outstanding = expected_records.size();
	end

endmodule

// File: dv/tb_delta_copy_list_encoder.sv
`timescale 1ns / 1ps

module tb_delta_copy_list_encoder import dcle_pkg::*;;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               opcode = OPC_COPY;
	logic [31:0]        old_offset = '0;
	logic [31:0]        old_length = '0;
	logic [31:0]        new_length = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic               kind;
	logic signed [31:0] offset_delta;
	logic [30:0]        copy_length;
	logic [31:0]        ext_run_count;
	logic [30:0]        data_length;
	logic               last;

	int fail_count;
	int outstanding;
	int seen_records;

	// stimulus phases shared with the receiver
	logic flood = 1'b0;
	logic quiet = 1'b0;

	int          n_items = 0;
	int          cycles = 0;
	logic [31:0] cursor = '0;

	always #5 clk = ~clk;

	delta_copy_list_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.old_offset   (old_offset),
		.old_length   (old_length),
		.new_length   (new_length),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.offset_delta (offset_delta),
		.copy_length  (copy_length),
		.ext_run_count(ext_run_count),
		.data_length  (data_length),
		.last         (last)
	);

	dcle_record_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.old_offset   (old_offset),
		.old_length   (old_length),
		.new_length   (new_length),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.offset_delta (offset_delta),
		.copy_length  (copy_length),
		.ext_run_count(ext_run_count),
		.data_length  (data_length),
		.last         (last),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.seen_records (seen_records)
	);

	function automatic logic [31:0] boundary_value();
		case ($urandom_range(0, 6))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h8000_0001;
			5: return 32'hFFFF_FFFF;
			default: return 32'hFFFF_FFFE;
		endcase
	endfunction

	// called and returns at a falling edge
	task automatic send_item(input logic op, input logic [31:0] off,
			input logic [31:0] olen, input logic [31:0] nlen);
		int gap;
		if (!quiet && !flood && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		old_offset <= off;
		old_length <= olen;
		new_length <= nlen;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		n_items++;
		@(negedge clk);
	endtask

	task automatic drain();
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// receiver: random stall bursts, one long hold-off during the flood phase, no stalls in the quiet phase
	initial begin
		bit held;
		int len;
		logic hold;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (flood && !held) begin
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				result_stall <= 1'b0;
			end else if (quiet) begin
				result_stall <= 1'b0;
			end else begin
				len = $urandom_range(1, 10);
				hold = ($urandom_range(0, 2) == 0);
				result_stall <= hold;
				repeat (len - 1) @(negedge clk);
			end
		end
	end

	initial begin
		int          r;
		logic [31:0] off;
		logic [31:0] olen;
		logic [31:0] nlen;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		send_item(OPC_COPY, 32'd0, 32'd0, 32'd0);
		send_item(OPC_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OPC_COPY, 32'd100, 32'd50, 32'd20);
		send_item(OPC_COPY, 32'd200, 32'd0, 32'd10);
		send_item(OPC_COPY, 32'd150, 32'd10, 32'd0);
		send_item(OPC_FINISH, 32'd0, 32'd0, 32'd0);
		send_item(OPC_COPY, 32'hFFFF_FFFF, 32'd1, 32'd0);
		send_item(OPC_COPY, 32'd0, 32'd5, 32'd1);
		send_item(OPC_COPY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(OPC_COPY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_item(OPC_COPY, 32'h0000_1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OPC_FINISH, 32'd0, 32'd0, 32'd0);
		send_item(OPC_COPY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OPC_COPY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OPC_FINISH, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
		send_item(OPC_COPY, 32'd0, 32'hFFFF_FFFF, 32'd0);
		send_item(OPC_COPY, 32'h8000_0000, 32'd0, 32'd0);
		send_item(OPC_FINISH, 32'd0, 32'd0, 32'd0);

		// random part: mostly plausible lists with some wild and boundary items
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 30)
				flood <= 1'b1;
			if (i == 55)
				flood <= 1'b0;
			if (i == 120)
				quiet <= 1'b1;
			if (i == 90) begin
				// pause the sender until the block has emptied
				item_valid <= 1'b0;
				@(negedge clk);
				drain();
			end
			r = $urandom_range(0, 99);
			if (r < 12) begin
				send_item(OPC_FINISH, $urandom, $urandom, $urandom);
				cursor = '0;
			end else begin
				if (r < 72) begin
					off = cursor + $urandom_range(0, 4000) - 32'd2000;
					olen = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom_range(1, 5000);
					nlen = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom_range(1, 5000);
				end else if (r < 86) begin
					off = $urandom;
					olen = $urandom;
					nlen = $urandom;
				end else begin
					off = boundary_value();
					olen = boundary_value();
					nlen = boundary_value();
				end
				send_item(OPC_COPY, off, olen, nlen);
				cursor = off + olen;
			end
		end

		item_valid <= 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d items: copies, finishes, split jumps and lengths, dropped overflow",
			n_items);
		$display("checked %0d records under random stalls, a long output hold-off and a drain",
			seen_records);
		if (fail_count == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
